// ===== hdl/multitap_keypad_text_entry_macros.svh =====
// assertion macros for the multi-tap keypad text entry block
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_MACROS_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_MACROS_SVH
`ifndef ASSERT_OFF
// property that holds at every clock edge
`define MKE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define MKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MKE_ASSERT(label, prop, msg)
`define MKE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/mke_pkg.sv =====
// ----------------------------------------------------------------------------
// mke_pkg
// Shared constants, types and helper functions for the keypad text entry.
// ----------------------------------------------------------------------------
package mke_pkg;

  // buffer geometry
  localparam int BUF_CHARS = 32;
  localparam int IDX_W     = $clog2(BUF_CHARS);
  localparam int LEN_W     = $clog2(BUF_CHARS + 1);

  // keypad and payload widths
  localparam int KEY_COUNT = 9;
  localparam int EVKEY_W   = 4;
  localparam int POS_W     = 5;
  localparam int CHAR_W    = 8;
  localparam int CNT_W     = 14;
  localparam int TAP_W     = 2;

  localparam logic [CNT_W-1:0]   CNT_MAX    = CNT_W'(9999);
  localparam logic [EVKEY_W-1:0] NO_KEY     = EVKEY_W'(15);
  localparam logic [CHAR_W-1:0]  SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0]  DIGIT_ONE  = 8'h31;

  // two-key combinations
  localparam logic [KEY_COUNT-1:0] COMBO_CLEAR = 9'h006;
  localparam logic [KEY_COUNT-1:0] COMBO_MODE  = 9'h030;
  localparam logic [KEY_COUNT-1:0] COMBO_SPACE = 9'h180;
  localparam logic [EVKEY_W-1:0]   EVKEY_MODE  = EVKEY_W'(5);
  localparam logic [EVKEY_W-1:0]   EVKEY_SPACE = EVKEY_W'(8);

  // commands from controller to datapath
  typedef struct packed {
    logic             edit;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_last;
  } mke_cmd_t;

  // multi-tap letter for a key and tap index
  function automatic logic [CHAR_W-1:0] letter_code(input logic [EVKEY_W-1:0] key,
                                                    input logic [TAP_W-1:0] tap);
    logic [3*CHAR_W-1:0] row;
    row = {SPACE_CHAR, SPACE_CHAR, SPACE_CHAR};
    unique case (key)
      4'd0:    row = {"Z", "Q", "."};
      4'd1:    row = {"C", "B", "A"};
      4'd2:    row = {"F", "E", "D"};
      4'd3:    row = {"I", "H", "G"};
      4'd4:    row = {"L", "K", "J"};
      4'd5:    row = {"O", "N", "M"};
      4'd6:    row = {"S", "R", "P"};
      4'd7:    row = {"V", "U", "T"};
      4'd8:    row = {"Y", "X", "W"};
      default: row = {SPACE_CHAR, SPACE_CHAR, SPACE_CHAR};
    endcase
    unique case (tap)
      2'd0:    return row[CHAR_W-1:0];
      2'd1:    return row[2*CHAR_W-1:CHAR_W];
      2'd2:    return row[3*CHAR_W-1:2*CHAR_W];
      default: return SPACE_CHAR;
    endcase
  endfunction

  // logical buffer offset to physical ram address, circular from head
  function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (sum >= (IDX_W+1)'(BUF_CHARS)) begin
      sum = sum - (IDX_W+1)'(BUF_CHARS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/mke_if.sv =====
// ----------------------------------------------------------------------------
// mke_if
// Valid/ready channel interfaces for key events and buffer characters.
// ----------------------------------------------------------------------------
interface mke_in_if;
  import mke_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_COUNT-1:0] pressed_keys;
  logic [EVKEY_W-1:0]   event_key;
  logic                 ignore_repeat;

  modport source (output valid, output pressed_keys, output event_key,
                  output ignore_repeat, input ready);
  modport sink (input valid, input pressed_keys, input event_key,
                input ignore_repeat, output ready);
endinterface

interface mke_out_if;
  import mke_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  char_pos;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;
  logic [CNT_W-1:0]  press_count;
  logic              numeric_mode;

  modport source (output valid, output char_pos, output char_code, output is_last,
                  output press_count, output numeric_mode, input ready);
  modport sink (input valid, input char_pos, input char_code, input is_last,
                input press_count, input numeric_mode, output ready);
endinterface

// ===== hdl/mke_ram.sv =====
// ----------------------------------------------------------------------------
// mke_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mke_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/mke_ctrl.sv =====
// ----------------------------------------------------------------------------
// mke_ctrl
// Controller: accepts key events, orders the edit and sequences the dump.
// ----------------------------------------------------------------------------
`include "multitap_keypad_text_entry_macros.svh"

module mke_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ignore,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mke_pkg::mke_cmd_t cmd
);
  import mke_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic             st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ov_r, ov_nxt;
  logic             accept;
  logic             issue;
  logic             at_last;

  // handshake decode
  assign in_ready = (st_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign issue    = (st_r == S_DUMP) && (!ov_r || out_ready);
  assign at_last  = (idx_r == IDX_W'(BUF_CHARS - 1));

  // commands to the datapath
  always_comb begin
    cmd.edit    = accept && !in_ignore;
    cmd.rd_en   = issue;
    cmd.rd_idx  = idx_r;
    cmd.rd_last = at_last;
  end

  // state sequencing
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept && !in_ignore) begin
          st_nxt  = S_DUMP;
          idx_nxt = '0;
        end
      end
      S_DUMP: begin
        if (issue) begin
          if (at_last) begin
            st_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // output stage occupancy
  always_comb begin
    if (issue) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  // checks
  `MKE_ASSERT_NEXT(a_edit_starts_dump, accept && !in_ignore, st_r == S_DUMP && idx_r == '0, "edit did not start dump at first position")
  `MKE_ASSERT(a_no_overwrite, !issue || !ov_r || out_ready, "read issued over a waiting item")
  `MKE_ASSERT_NEXT(a_last_ends_dump, issue && at_last, st_r == S_IDLE && ov_r, "dump did not end after last read")
  `MKE_ASSERT_NEXT(a_ignore_no_dump, accept && in_ignore, st_r == S_IDLE, "ignored event started a dump")

endmodule

// ===== hdl/mke_dp.sv =====
// ----------------------------------------------------------------------------
// mke_dp
// Datapath: text buffer, edit state, key decode and output register.
// ----------------------------------------------------------------------------
module mke_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mke_pkg::mke_cmd_t               cmd,
  input  logic [mke_pkg::KEY_COUNT-1:0]   pressed_keys,
  input  logic [mke_pkg::EVKEY_W-1:0]     event_key,
  output logic [mke_pkg::POS_W-1:0]       char_pos,
  output logic [mke_pkg::CHAR_W-1:0]      char_code,
  output logic                            is_last,
  output logic [mke_pkg::CNT_W-1:0]       press_count,
  output logic                            numeric_mode
);
  import mke_pkg::*;

  // edit state
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [EVKEY_W-1:0] lkey_r, lkey_nxt;
  logic [TAP_W-1:0]   tap_r, tap_nxt;
  logic               mode_r, mode_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BUF_CHARS-1:0] vld_r, vld_nxt;

  // key decode
  logic [3:0]         held;
  logic [EVKEY_W-1:0] top;

  // edit actions
  logic               app_en;
  logic [CHAR_W-1:0]  app_char;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [CHAR_W-1:0]  wr_data;
  logic [TAP_W-1:0]   tap_adv;

  // read side
  logic [IDX_W-1:0]   rd_addr;
  logic [CHAR_W-1:0]  rd_data;
  logic [IDX_W-1:0]   pos_q;
  logic               last_q;
  logic               vld_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               mode_q;

  // held key count and highest held key
  always_comb begin
    held = '0;
    top  = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (pressed_keys[k]) begin
        held = held + 4'd1;
        top  = EVKEY_W'(k);
      end
    end
  end

  assign tap_adv = (tap_r == 2'd2) ? 2'd0 : tap_r + 2'd1;

  // edit decode
  always_comb begin
    head_nxt = head_r;
    len_nxt  = len_r;
    lkey_nxt = lkey_r;
    tap_nxt  = tap_r;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    vld_nxt  = vld_r;
    app_en   = 1'b0;
    app_char = SPACE_CHAR;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = SPACE_CHAR;

    if (cmd.edit) begin
      cnt_nxt = (cnt_r == CNT_MAX) ? '0 : cnt_r + 1'b1;
      if (held == 4'd1) begin
        if (mode_r) begin
          // digit entry
          app_en   = 1'b1;
          app_char = DIGIT_ONE + CHAR_W'(top);
          lkey_nxt = NO_KEY;
        end else if (top == lkey_r && len_r != '0) begin
          // repeat tap rewrites the last character
          tap_nxt = tap_adv;
          wr_en   = 1'b1;
          wr_addr = phys_addr(head_r, IDX_W'(len_r - 1'b1));
          wr_data = letter_code(top, tap_adv);
        end else begin
          // new letter key
          app_en   = 1'b1;
          app_char = letter_code(top, 2'd0);
          lkey_nxt = top;
          tap_nxt  = '0;
        end
      end else if (held == 4'd2) begin
        if ((pressed_keys & COMBO_CLEAR) == COMBO_CLEAR) begin
          vld_nxt = '0;
          len_nxt = '0;
        end else if ((pressed_keys & COMBO_MODE) == COMBO_MODE &&
                     event_key == EVKEY_MODE) begin
          mode_nxt = !mode_r;
        end else if ((pressed_keys & COMBO_SPACE) == COMBO_SPACE &&
                     event_key == EVKEY_SPACE) begin
          app_en   = 1'b1;
          app_char = SPACE_CHAR;
          tap_nxt  = '0;
          lkey_nxt = NO_KEY;
        end
      end
    end

    // append, full buffer rotates the head so the oldest slot becomes the tail
    if (app_en) begin
      wr_en   = 1'b1;
      wr_data = app_char;
      if (len_r == LEN_W'(BUF_CHARS)) begin
        wr_addr  = head_r;
        head_nxt = phys_addr(head_r, IDX_W'(1));
      end else begin
        wr_addr = phys_addr(head_r, IDX_W'(len_r));
        len_nxt = len_r + 1'b1;
      end
    end

    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      len_r  <= '0;
      lkey_r <= NO_KEY;
      tap_r  <= '0;
      mode_r <= 1'b0;
      cnt_r  <= '0;
      vld_r  <= '0;
    end else begin
      head_r <= head_nxt;
      len_r  <= len_nxt;
      lkey_r <= lkey_nxt;
      tap_r  <= tap_nxt;
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      vld_r  <= vld_nxt;
    end
  end

  // text buffer
  assign rd_addr = phys_addr(head_r, cmd.rd_idx);

  mke_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(BUF_CHARS)
  ) u_buf (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // output register, loaded alongside the ram read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pos_q  <= cmd.rd_idx;
      last_q <= cmd.rd_last;
      vld_q  <= vld_r[rd_addr];
      cnt_q  <= cnt_r;
      mode_q <= mode_r;
    end
  end

  assign char_pos     = POS_W'(pos_q);
  assign char_code    = vld_q ? rd_data : SPACE_CHAR;
  assign is_last      = last_q;
  assign press_count  = cnt_q;
  assign numeric_mode = mode_q;

endmodule

// ===== hdl/multitap_keypad_text_entry.sv =====
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry
// Multi-tap keypad text entry: edits a text buffer per key event and dumps it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one key event per item: held-key bitmap, highest key and a
//          repeat flag. A repeat item is taken and does nothing.
//   out_ch carries the buffer dump: one item per position, 32 items per event,
//          the last one flagged, each with the press count and entry mode.
//   an event is taken while the block is idle; the edit is done at the edge
//   that takes it. The first character is valid once the controller has
//   entered its dump state and the RAM read has loaded the output register,
//   then one character per cycle as long as the receiver keeps ready high.
//   The dump reads one position per cycle through the single read port of
//   the buffer RAM, and no new event is taken until every position is read.
//   in_ready rises again as the last character enters the output register,
//   so the next event may be taken while that character waits.
// Stall:
//   with out_ch.ready low, the output register and the RAM read hold; reading
//   resumes once the waiting item is taken.
// Reset:
//   synchronous, active low. The buffer reads as all spaces, length and mode
//   are cleared and no key is pending; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry (
  input logic       clk,
  input logic       rst_n,
  mke_in_if.sink    in_ch,
  mke_out_if.source out_ch
);
  import mke_pkg::*;

  mke_cmd_t cmd;

  // controller
  mke_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ignore(in_ch.ignore_repeat),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd)
  );

  // datapath
  mke_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .pressed_keys(in_ch.pressed_keys),
    .event_key   (in_ch.event_key),
    .char_pos    (out_ch.char_pos),
    .char_code   (out_ch.char_code),
    .is_last     (out_ch.is_last),
    .press_count (out_ch.press_count),
    .numeric_mode(out_ch.numeric_mode)
  );

endmodule
